FILE: design/mgps_pkg.sv
// Package with the shared types and constants of the gate pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mgps_pkg;

  localparam int unsigned SAMPLE_IN_W = 12;
  localparam int unsigned ROW_IN_W    = 3;
  localparam int unsigned STEP_IN_W   = 5;
  localparam int unsigned VALUE_IN_W  = 6;
  localparam int unsigned AUX_W       = 2;

  typedef enum logic [1:0] {
    OP_RISE = 2'd0,
    OP_FALL = 2'd1,
    OP_LEN  = 2'd2,
    OP_BIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    AUX_OR  = 2'd0,
    AUX_AND = 2'd1,
    AUX_XOR = 2'd2,
    AUX_NOR = 2'd3
  } aux_e;

  typedef enum logic [1:0] {
    PAIR_A,
    PAIR_B,
    PAIR_OFF
  } pair_e;

  typedef enum logic [1:0] {
    JOB_A_BASE,
    JOB_B,
    JOB_A_IDX
  } job_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MUL_A,
    S_MUL_B,
    S_MUL_O,
    S_FIN_O,
    S_MOD_LOAD,
    S_MOD_RUN,
    S_READ,
    S_GATES,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e                    op;
    logic [SAMPLE_IN_W-1:0] knob_a;
    logic [SAMPLE_IN_W-1:0] knob_b;
    logic [SAMPLE_IN_W-1:0] knob_offset;
    logic [SAMPLE_IN_W-1:0] cv_a;
    logic [SAMPLE_IN_W-1:0] cv_b;
    logic [SAMPLE_IN_W-1:0] cv_offset;
    logic                   grid_select;
    logic [ROW_IN_W-1:0]    table_row;
    logic [STEP_IN_W-1:0]   table_step;
    logic [VALUE_IN_W-1:0]  table_value;
  } item_t;

  typedef struct packed {
    logic gate_aux;
    logic gate_b;
    logic gate_a;
  } gates_t;

  typedef struct packed {
    logic  latch;
    logic  clr_write;
    logic  len_write;
    logic  bit_write;
    logic  gates_clear;
    logic  mul_en;
    pair_e mul_pair;
    logic  fin_en;
    pair_e fin_pair;
    logic  len_load;
    logic  mod_load;
    logic  mod_step;
    job_e  job;
    logic  gates_set;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_e  op;
    logic mod_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/mgps_if.sv
// Handshake channel interfaces for items, results and the configuration register.
`timescale 1ns / 1ps
`default_nettype none

interface mgps_in_if;
  import mgps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [SAMPLE_IN_W-1:0] knob_a;
  logic [SAMPLE_IN_W-1:0] knob_b;
  logic [SAMPLE_IN_W-1:0] knob_offset;
  logic [SAMPLE_IN_W-1:0] cv_a;
  logic [SAMPLE_IN_W-1:0] cv_b;
  logic [SAMPLE_IN_W-1:0] cv_offset;
  logic                   grid_select;
  logic [ROW_IN_W-1:0]    table_row;
  logic [STEP_IN_W-1:0]   table_step;
  logic [VALUE_IN_W-1:0]  table_value;

  modport source (
    output valid, op, knob_a, knob_b, knob_offset, cv_a, cv_b, cv_offset,
    output grid_select, table_row, table_step, table_value,
    input  ready
  );
  modport sink (
    input  valid, op, knob_a, knob_b, knob_offset, cv_a, cv_b, cv_offset,
    input  grid_select, table_row, table_step, table_value,
    output ready
  );
endinterface

interface mgps_out_if;
  logic valid;
  logic ready;
  logic gate_a;
  logic gate_b;
  logic gate_aux;

  modport source (output valid, gate_a, gate_b, gate_aux, input ready);
  modport sink (input valid, gate_a, gate_b, gate_aux, output ready);
endinterface

interface mgps_cfg_if;
  import mgps_pkg::*;
  logic             valid;
  logic             ready;
  logic [AUX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/mgps_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mgps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/mgps_ctrl.sv
// Controller state machine that sequences clearing, loads and the step computation.
`timescale 1ns / 1ps
`default_nettype none

module mgps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mgps_pkg::sts_t sts_i,
  output mgps_pkg::cmd_t cmd_o
);
  import mgps_pkg::*;

  state_e state_q, state_d;
  job_e   job_q, job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      job_q   <= JOB_A_BASE;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.job  = job_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_EMIT;
        case (sts_i.op)
          OP_RISE: state_d = S_MUL_A;
          OP_FALL: cmd_o.gates_clear = 1'b1;
          OP_LEN:  cmd_o.len_write = 1'b1;
          OP_BIT:  cmd_o.bit_write = 1'b1;
          default: state_d = S_EMIT;
        endcase
      end
      S_MUL_A: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_pair = PAIR_A;
        state_d        = S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_pair = PAIR_B;
        cmd_o.fin_en   = 1'b1;
        cmd_o.fin_pair = PAIR_A;
        state_d        = S_MUL_O;
      end
      S_MUL_O: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_pair = PAIR_OFF;
        cmd_o.fin_en   = 1'b1;
        cmd_o.fin_pair = PAIR_B;
        state_d        = S_FIN_O;
      end
      S_FIN_O: begin
        cmd_o.fin_en   = 1'b1;
        cmd_o.fin_pair = PAIR_OFF;
        cmd_o.len_load = 1'b1;
        job_d          = JOB_A_BASE;
        state_d        = S_MOD_LOAD;
      end
      S_MOD_LOAD: begin
        cmd_o.mod_load = 1'b1;
        state_d        = S_MOD_RUN;
      end
      S_MOD_RUN: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          case (job_q)
            JOB_A_BASE: begin
              job_d   = JOB_B;
              state_d = S_MOD_LOAD;
            end
            JOB_B: begin
              job_d   = JOB_A_IDX;
              state_d = S_MOD_LOAD;
            end
            default: state_d = S_READ;
          endcase
        end
      end
      S_READ: begin
        state_d = S_GATES;
      end
      S_GATES: begin
        cmd_o.gates_set = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A second item was taken before the first one finished.");

  a_last_job_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD_RUN && job_q == JOB_A_IDX && sts_i.mod_last) |=> state_q == S_READ)
    else $error("The final modulo job did not lead to the pattern read.");

  a_read_after_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (job_q == JOB_A_IDX))
    else $error("The pattern read started before all modulo jobs ran.");
`endif

endmodule

`default_nettype wire

FILE: design/mgps_dp.sv
// Datapath with the morph multiplier, the modulo unit, the row stores and the gate registers.
`timescale 1ns / 1ps
`default_nettype none

module mgps_dp #(
  parameter int unsigned MAX_STEPS   = 32,
  parameter int unsigned NUM_ROWS    = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mgps_pkg::item_t            item_i,
  input  logic                       cfg_valid_i,
  input  logic [mgps_pkg::AUX_W-1:0] cfg_data_i,
  input  mgps_pkg::cmd_t             cmd_i,
  output mgps_pkg::sts_t             sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mgps_pkg::gates_t           out_gates_o
);
  import mgps_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned RowW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_STEPS);
  localparam int unsigned LenW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned ModW   = $clog2(MAX_STEPS + 15);
  localparam int unsigned BitW   = $clog2(ModW);
  localparam int unsigned Depth  = NUM_ROWS * MAX_STEPS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned ProdW  = SB + 16;
  localparam int unsigned TPadW  = 17 - SB;
  localparam int unsigned RowCW  = ROW_IN_W + 1;
  localparam int unsigned StepCW = STEP_IN_W + 2;

  localparam logic [RowCW-1:0]  NumRowsC  = RowCW'(NUM_ROWS);
  localparam logic [StepCW-1:0] MaxStepsC = StepCW'(MAX_STEPS);
  localparam logic [LenW-1:0]   MaxLen    = LenW'(MAX_STEPS);
  localparam logic [AddrW-1:0]  RowStride = AddrW'(MAX_STEPS);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
  localparam logic [BitW-1:0]   LastBit   = BitW'(ModW - 1);

  function automatic logic [RowW-1:0] row_of(input logic [SB-1:0] m);
    logic [SB+3:0] scaled;
    logic [3:0]    full;
    scaled = (SB + 4)'(m) * (SB + 4)'(NUM_ROWS);
    full   = scaled[SB+3:SB];
    if (full >= 4'(NUM_ROWS)) begin
      full = 4'(NUM_ROWS - 1);
    end
    return RowW'(full);
  endfunction

  item_t            item_q;
  aux_e             aux_q;
  logic [AddrW-1:0] clr_q;
  logic [LenW-1:0]  a_len_q [NUM_ROWS];
  logic [LenW-1:0]  b_len_q [NUM_ROWS];
  logic [SB-1:0]    prod_hi_q, lo_q;
  logic [RowW-1:0]  ra_q, rb_q;
  logic [3:0]       off_q;
  logic [LenW-1:0]  la_q, lb_q;
  logic [ModW-1:0]  mx_q;
  logic [LenW-1:0]  rem_q;
  logic [BitW-1:0]  bit_q;
  logic [CntW-1:0]  amod_q, ib_q, ia_q;
  logic [CntW-1:0]  a_cnt_q, b_cnt_q;
  gates_t           gate_q, out_q;
  logic             out_valid_q;

  logic [SB-1:0]    knob_s, cv_s, inv, diff, lo, m;
  logic [15:0]      t;
  logic [ProdW-1:0] prod;
  logic [LenW-1:0]  len_v, mod_div, rem_n;
  logic [LenW:0]    rem_sh, rem_sub;
  logic [ModW-1:0]  mod_x;
  logic             row_ok, step_ok, out_free;
  logic [RowW-1:0]  row_idx;
  logic [AddrW-1:0] bit_addr, waddr, a_raddr, b_raddr;
  logic             a_we, b_we;
  logic [0:0]       wdata, a_rd, b_rd;
  logic [LenW-1:0]  a_inc, b_inc;
  logic [CntW-1:0]  a_next, b_next;
  logic             aux_v;

  // Morph of one knob and CV pair: both halves share one multiply.
  always_comb begin
    case (cmd_i.mul_pair)
      PAIR_A: begin
        knob_s = SB'(item_q.knob_a);
        cv_s   = SB'(item_q.cv_a);
      end
      PAIR_B: begin
        knob_s = SB'(item_q.knob_b);
        cv_s   = SB'(item_q.cv_b);
      end
      default: begin
        knob_s = SB'(item_q.knob_offset);
        cv_s   = SB'(item_q.cv_offset);
      end
    endcase
    inv  = ~cv_s;
    t    = {inv[SB-2:0], {TPadW{1'b0}}};
    diff = inv[SB-1] ? ~knob_s : knob_s;
    lo   = inv[SB-1] ? knob_s : '0;
    prod = ProdW'(diff) * ProdW'(t);
  end

  assign m = lo_q + prod_hi_q;

  always_comb begin
    row_ok  = RowCW'(item_q.table_row) < NumRowsC;
    step_ok = StepCW'(item_q.table_step) < MaxStepsC;
    row_idx = RowW'(item_q.table_row);
    if (item_q.table_value == '0) begin
      len_v = LenW'(1);
    end else if (StepCW'(item_q.table_value) > MaxStepsC) begin
      len_v = MaxLen;
    end else begin
      len_v = LenW'(item_q.table_value);
    end
  end

  // Restoring modulo, one dividend bit per cycle.
  always_comb begin
    mod_div = (cmd_i.job == JOB_B) ? lb_q : la_q;
    case (cmd_i.job)
      JOB_A_BASE: mod_x = ModW'(a_cnt_q);
      JOB_B:      mod_x = ModW'(b_cnt_q);
      default:    mod_x = ModW'(amod_q) + ModW'(off_q);
    endcase
    rem_sh  = {rem_q, mx_q[ModW-1]};
    rem_sub = rem_sh - {1'b0, mod_div};
    rem_n   = (rem_sh >= {1'b0, mod_div}) ? LenW'(rem_sub) : LenW'(rem_sh);
  end

  always_comb begin
    bit_addr = AddrW'(item_q.table_row) * RowStride + AddrW'(item_q.table_step);
    waddr    = cmd_i.clr_write ? clr_q : bit_addr;
    wdata    = cmd_i.clr_write ? 1'b0 : (item_q.table_value != '0);
    a_we     = cmd_i.clr_write ||
               (cmd_i.bit_write && row_ok && step_ok && !item_q.grid_select);
    b_we     = cmd_i.clr_write ||
               (cmd_i.bit_write && row_ok && step_ok && item_q.grid_select);
    a_raddr  = AddrW'(ra_q) * RowStride + AddrW'(ia_q);
    b_raddr  = AddrW'(rb_q) * RowStride + AddrW'(ib_q);
  end

  always_comb begin
    a_inc  = LenW'(amod_q) + LenW'(1);
    b_inc  = LenW'(ib_q) + LenW'(1);
    a_next = (a_inc == la_q) ? '0 : CntW'(a_inc);
    b_next = (b_inc == lb_q) ? '0 : CntW'(b_inc);
    case (aux_q)
      AUX_OR:  aux_v = a_rd[0] | b_rd[0];
      AUX_AND: aux_v = a_rd[0] & b_rd[0];
      AUX_XOR: aux_v = a_rd[0] ^ b_rd[0];
      default: aux_v = ~(a_rd[0] | b_rd[0]);
    endcase
  end

  mgps_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rd)
  );

  mgps_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.mul_en) begin
      prod_hi_q <= prod[ProdW-1:16];
      lo_q      <= lo;
    end
    if (cmd_i.fin_en) begin
      case (cmd_i.fin_pair)
        PAIR_A:  ra_q <= row_of(m);
        PAIR_B:  rb_q <= row_of(m);
        default: off_q <= m[SB-1 -: 4];
      endcase
    end
    if (cmd_i.len_load) begin
      la_q <= a_len_q[ra_q];
      lb_q <= b_len_q[rb_q];
    end
    if (cmd_i.mod_load) begin
      mx_q  <= mod_x;
      rem_q <= '0;
      bit_q <= LastBit;
    end else if (cmd_i.mod_step) begin
      mx_q  <= {mx_q[ModW-2:0], 1'b0};
      rem_q <= rem_n;
      bit_q <= bit_q - BitW'(1);
      if (bit_q == '0) begin
        case (cmd_i.job)
          JOB_A_BASE: amod_q <= CntW'(rem_n);
          JOB_B:      ib_q <= CntW'(rem_n);
          default:    ia_q <= CntW'(rem_n);
        endcase
      end
    end
    if (cmd_i.emit) begin
      out_q <= gate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aux_q       <= AUX_OR;
      clr_q       <= '0;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      gate_q      <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        a_len_q[r] <= LenW'(1);
        b_len_q[r] <= LenW'(1);
      end
    end else begin
      if (cfg_valid_i) begin
        aux_q <= aux_e'(cfg_data_i);
      end
      if (cmd_i.clr_write) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.len_write && row_ok) begin
        if (item_q.grid_select) begin
          b_len_q[row_idx] <= len_v;
        end else begin
          a_len_q[row_idx] <= len_v;
        end
      end
      if (cmd_i.gates_set) begin
        a_cnt_q <= a_next;
        b_cnt_q <= b_next;
        gate_q  <= '{gate_aux: aux_v, gate_b: b_rd[0], gate_a: a_rd[0]};
      end else if (cmd_i.gates_clear) begin
        gate_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free       = !out_valid_q || out_ready_i;
  assign sts_o.clr_last = (clr_q == LastAddr);
  assign sts_o.op       = item_q.op;
  assign sts_o.mod_last = (bit_q == '0);
  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_valid_q;
  assign out_gates_o    = out_q;

`ifndef SYNTHESIS
  a_a_count_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gates_set |=> LenW'(a_cnt_q) < la_q)
    else $error("Track A step count left its row length.");

  a_b_count_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gates_set |=> LenW'(b_cnt_q) < lb_q)
    else $error("Track B step count left its row length.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_step |=> rem_q < $past(mod_div))
    else $error("Modulo remainder is not below the divisor.");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("A result appeared without an emit command.");
`endif

endmodule

`default_nettype wire

FILE: design/morphing_gate_pattern_sequencer_core.sv
// Top level of the morphing two-track gate pattern sequencer.
//
//   Channel  Dir  Handshake            Carries
//   in_i     in   in_i.valid/ready     op, knobs, CV samples, store load fields
//   out_o    out  out_o.valid/ready    gate_a, gate_b, gate_aux
//   cfg_i    in   cfg_i.valid/ready    aux_logic_mode (ready is always high)
//
// A clock rising item runs the morph multiply for track A, track B and the offset,
// then the shared bit-serial modulo unit three times, each run over MOD_W =
// clog2(MAX_STEPS+15) dividend bits, then the pattern read; other items skip them.
// After reset every entry of both pattern RAMs is cleared before the
// first item is accepted. One item is in work at a time; a result waiting on out_o
// holds back only the end of the next item.
`timescale 1ns / 1ps
`default_nettype none

module morphing_gate_pattern_sequencer_core #(
  parameter int unsigned MAX_STEPS   = 32,
  parameter int unsigned NUM_ROWS    = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  mgps_in_if.sink    in_i,
  mgps_out_if.source out_o,
  mgps_cfg_if.sink   cfg_i
);
  import mgps_pkg::*;

  item_t  item;
  cmd_t   cmd;
  sts_t   sts;
  gates_t out_gates;
  logic   in_ready;
  logic   out_valid;

  assign item.op          = op_e'(in_i.op);
  assign item.knob_a      = in_i.knob_a;
  assign item.knob_b      = in_i.knob_b;
  assign item.knob_offset = in_i.knob_offset;
  assign item.cv_a        = in_i.cv_a;
  assign item.cv_b        = in_i.cv_b;
  assign item.cv_offset   = in_i.cv_offset;
  assign item.grid_select = in_i.grid_select;
  assign item.table_row   = in_i.table_row;
  assign item.table_step  = in_i.table_step;
  assign item.table_value = in_i.table_value;

  assign in_i.ready    = in_ready;
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid;
  assign out_o.gate_a  = out_gates.gate_a;
  assign out_o.gate_b  = out_gates.gate_b;
  assign out_o.gate_aux = out_gates.gate_aux;

  mgps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mgps_dp #(
    .MAX_STEPS   (MAX_STEPS),
    .NUM_ROWS    (NUM_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_gates_o (out_gates)
  );

endmodule

`default_nettype wire
